FILE: rtl/core/swks_pkg.sv
// Shared types, widths and the gain-table builder for the sliding-window Kalman smoother.
// Used by swks_ctrl, swks_dp and sliding_window_kalman_smoother_core; depends on nothing.

package swks_pkg;

    localparam int WINDOW_MAX_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int GAIN_W         = 16;
    // The estimate and the running difference carry two guard bits over the sample width.
    localparam int EST_W          = 34;

    // Register indexes of the configuration port and the window length after reset.
    localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] CFG_MIN_LEVEL     = 2'd1;
    localparam logic [5:0] WINDOW_LENGTH_RST = 6'd8;

    // Commands from the controller to the datapath, at most a few active per cycle.
    typedef struct packed {
        logic load;       // capture the incoming sample
        logic fill_wr;    // priming write of the held sample at the slot index
        logic wr_new;     // write the held sample into the newest slot, rewind the read pointer
        logic rd;         // read the window at the read pointer and advance it
        logic init;       // start a recursion: estimate zero, difference equals first slot
        logic mul;        // multiply difference by gain, form next slot minus estimate
        logic acc;        // update estimate and next difference with the rounded product
        logic out_raw;    // load the output register with the held sample
        logic out_est;    // load the output register with the saturated estimate
        logic shift;      // copy the word just read into the slot below it
    } t_dp_cmd;

    typedef struct packed {
        logic in_ge_min;  // incoming sample is at or above the priming level
    } t_dp_status;

    // floor(num * 2^32 / den) for num < den, by restoring division. Elaboration use only.
    function automatic logic [63:0] f_frac_q32(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        int          n;
        rem = num;
        quo = '0;
        for (n = 0; n < 32; n++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Q0.16 gain of one window slot. The Q0.32 gain follows
    // k(i+1) = (k(i) + a) / (k(i) + 1 + a) with a = 1/500, truncated each step,
    // and is rounded to Q0.16 with halves going up.
    function automatic logic [GAIN_W-1:0] f_gain(input int idx);
        logic [63:0] kq;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rnd;
        int          n;
        kq = f_frac_q32(64'd100001, 64'd100501);
        for (n = 0; n < idx; n++) begin
            num = 64'd500 * kq + (64'd1 << 32);
            den = 64'd500 * kq + 64'd501 * (64'd1 << 32);
            kq  = f_frac_q32(num, den);
        end
        rnd = (kq + 64'd32768) >> 16;
        return rnd[GAIN_W-1:0];
    endfunction

endpackage

FILE: rtl/core/swks_dp.sv
// Datapath of the smoother: window memory, gain table, multiplier,
// estimate update and output register. Depends on swks_pkg; driven by swks_ctrl.

module swks_dp import swks_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                            i_clk,
    input  t_dp_cmd                         i_cmd,
    input  logic [$clog2(WINDOW_MAX)-1:0]   i_slot,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] i_len,
    input  logic signed [DATA_W-1:0]        i_min_level,
    input  logic signed [DATA_W-1:0]        i_sample,
    output t_dp_status                      o_status,
    output logic signed [DATA_W-1:0]        o_smoothed,
    output logic                            o_passed_raw
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int PW = EST_W + GAIN_W + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_MAX - 1);

    logic [DATA_W-1:0] r_mem [WINDOW_MAX];
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] r_sample;
    logic [AW-1:0]     r_raddr;
    logic signed [EST_W-1:0] r_est;
    logic signed [EST_W-1:0] r_diff;
    logic signed [EST_W-1:0] r_xe;
    logic signed [PW-1:0]    r_prod;
    logic signed [DATA_W-1:0] r_smoothed;
    logic                     r_passed;

    logic [GAIN_W-1:0]       w_gain_tab [WINDOW_MAX];
    logic [GAIN_W-1:0]       w_gain;
    logic [LW-1:0]           w_tail;
    logic [AW-1:0]           w_waddr;
    logic [DATA_W-1:0]       w_wdata;
    logic                    w_we;
    logic [AW-1:0]           w_raddr_next;
    logic signed [EST_W-1:0] w_x;
    logic signed [PW-1:0]    w_prod;
    logic signed [PW-1:0]    w_rnd;
    logic signed [EST_W-1:0] w_term;
    logic [DATA_W-1:0]       w_sat;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_gain
        localparam logic [GAIN_W-1:0] GAIN = f_gain(g);
        assign w_gain_tab[g] = GAIN;
    end

    assign w_gain = w_gain_tab[i_slot];

    // Slots keep fixed places. The shift copies each slot down as the recursion reads it,
    // so the newest slot and every slot past it keep their contents.
    assign w_tail       = i_len - LW'(1);
    assign w_raddr_next = (r_raddr == LAST_IDX) ? '0 : (r_raddr + AW'(1));

    assign w_we    = i_cmd.fill_wr || i_cmd.wr_new || i_cmd.shift;
    assign w_waddr = i_cmd.wr_new ? w_tail[AW-1:0] : i_slot;
    assign w_wdata = i_cmd.shift ? r_rd : r_sample;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_raddr];
        end
    end

    assign w_x    = {{(EST_W - DATA_W){r_rd[DATA_W-1]}}, r_rd};
    assign w_prod = r_diff * $signed({1'b0, w_gain});
    // Round to nearest with halves up, then floor by taking the upper bits.
    assign w_rnd  = r_prod + PW'(32768);
    assign w_term = w_rnd[16 +: EST_W];

    always_comb begin
        if (r_est[EST_W-1:DATA_W-1] == '0 || r_est[EST_W-1:DATA_W-1] == '1) begin
            w_sat = r_est[DATA_W-1:0];
        end else if (r_est[EST_W-1]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.wr_new) begin
            r_raddr <= '0;
        end else if (i_cmd.rd) begin
            r_raddr <= w_raddr_next;
        end
        if (i_cmd.init) begin
            r_est  <= '0;
            r_diff <= w_x;
        end else if (i_cmd.acc) begin
            r_est  <= r_est + w_term;
            r_diff <= r_xe - w_term;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
            r_xe   <= w_x - r_est;
        end
        if (i_cmd.out_raw) begin
            r_smoothed <= r_sample;
            r_passed   <= 1'b1;
        end else if (i_cmd.out_est) begin
            r_smoothed <= w_sat;
            r_passed   <= 1'b0;
        end
    end

    assign o_status.in_ge_min = (i_sample >= i_min_level);
    assign o_smoothed         = r_smoothed;
    assign o_passed_raw       = r_passed;

endmodule

FILE: rtl/core/swks_ctrl.sv
// Controller of the smoother: handshakes, priming flag, slot counter and the
// sequence of datapath commands. Depends on swks_pkg; drives swks_dp.

module swks_ctrl import swks_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] i_len,
    input  t_dp_status                      i_status,
    output t_dp_cmd                         o_cmd,
    output logic [$clog2(WINDOW_MAX)-1:0]   o_slot
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int LW = $clog2(WINDOW_MAX + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_PASS,
        ST_WR,
        ST_RD0,
        ST_PRE,
        ST_MUL,
        ST_ACC,
        ST_FIN
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_cnt;
    logic          r_primed;
    logic          r_out_vld;

    logic w_in_acc;
    logic w_out_free;
    logic w_last;
    logic w_fill_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_slot      = r_cnt;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_last      = (LW'(r_cnt) == (i_len - LW'(1)));
    assign w_fill_last = (LW'(r_cnt) == (i_len - LW'(2)));

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: o_cmd.load    = w_in_acc;
            ST_FILL: o_cmd.fill_wr = 1'b1;
            ST_PASS: o_cmd.out_raw = w_out_free;
            ST_WR:   o_cmd.wr_new  = 1'b1;
            ST_RD0:  o_cmd.rd      = 1'b1;
            ST_PRE: begin
                o_cmd.rd   = 1'b1;
                o_cmd.init = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul   = 1'b1;
                o_cmd.shift = !w_last;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                o_cmd.rd  = !w_last;
            end
            ST_FIN:  o_cmd.out_est = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_primed  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_cmd.out_raw || o_cmd.out_est) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cnt <= '0;
                        if (r_primed) begin
                            r_state <= ST_WR;
                        end else if (i_status.in_ge_min) begin
                            r_primed <= 1'b1;
                            r_state  <= ST_FILL;
                        end else begin
                            r_state <= ST_PASS;
                        end
                    end
                end
                ST_FILL: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (w_fill_last) begin
                        r_state <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_WR:  r_state <= ST_RD0;
                ST_RD0: r_state <= ST_PRE;
                ST_PRE: begin
                    r_cnt   <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: r_state <= ST_ACC;
                ST_ACC: begin
                    if (w_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt   <= r_cnt + AW'(1);
                        r_state <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_ACC) |-> (LW'(r_cnt) < i_len))
        else $error("slot counter ran past the window length");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_raw || o_cmd.out_est) |-> (!r_out_vld || !i_out_stall))
        else $error("output register loaded while a stalled result was still held");

    a_primed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_primed))
        else $error("primed flag cleared outside reset");

    a_filter_only_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> r_primed)
        else $error("filter pass started before the window was primed");

endmodule

FILE: rtl/core/sliding_window_kalman_smoother_core.sv
// Top level of the sliding-window scalar Kalman smoother: configuration registers,
// window-length clamp, controller and datapath. Depends on swks_pkg, swks_ctrl, swks_dp.
//
//   Channel  Direction  Handshake                 Payload
//   in       sink       i_in_valid / o_in_stall   i_sample
//   out      source     o_out_valid / i_out_stall o_smoothed, o_passed_raw
//   cfg      sink       i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// A filtered beat steps through ST_WR, ST_RD0, ST_PRE, then ST_MUL and ST_ACC for each
// slot of the clamped window length, and ST_FIN, which loads the output register once it
// is free; each slot goes through the single shared multiplier and then the estimate
// update that depends on it. A pass-through beat loads the output register in ST_PASS and
// the priming beat does so after ST_FILL has written all but the newest slot. Either way
// the next beat is taken only once the controller is back in ST_IDLE.
// Reset is synchronous and active low; it clears the priming flag and the handshakes,
// and the window memory is left as it is; priming fills it before the first filter pass.
// The output register holds a finished result under i_out_stall while the next input
// beat is taken; a further result waits in the controller until that register is free.

module sliding_window_kalman_smoother_core import swks_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_smoothed,
    output logic                     o_passed_raw,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int LW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (LW > 6) ? LW : 6;

    logic [5:0]               r_window_length;
    logic signed [DATA_W-1:0] r_min_level;

    logic [CW-1:0] w_wl_ext;
    logic [LW-1:0] w_len;
    t_dp_cmd       w_cmd;
    t_dp_status    w_status;
    logic [AW-1:0] w_slot;

    // Writes to an index beyond the two registers are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RST;
            r_min_level     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[5:0];
                CFG_MIN_LEVEL:     r_min_level     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The programmed length is clamped to the range the window memory supports.
    assign w_wl_ext = CW'(r_window_length);

    always_comb begin
        if (w_wl_ext < CW'(2)) begin
            w_len = LW'(2);
        end else if (w_wl_ext > CW'(WINDOW_MAX)) begin
            w_len = LW'(WINDOW_MAX);
        end else begin
            w_len = LW'(w_wl_ext);
        end
    end

    swks_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_len       (w_len),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_slot      (w_slot)
    );

    swks_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_slot       (w_slot),
        .i_len        (w_len),
        .i_min_level  (r_min_level),
        .i_sample     (i_sample),
        .o_status     (w_status),
        .o_smoothed   (o_smoothed),
        .o_passed_raw (o_passed_raw)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for sliding_window_kalman_smoother_core: directed table, then random phases.
// Depends on swks_pkg and the core RTL only; expected beats come from an in-bench Kalman predictor.

module tb_top;
    import swks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_MAX    = WINDOW_MAX_DEF;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BEATS   = 100;
    // The receiver stops taking results once, for this many cycles, after this many results.
    localparam int PRESSURE_AT   = 250;
    localparam int PRESSURE_HOLD = 500;

    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

    // Register indexes of the configuration port; the last two are not decoded by the block.
    typedef enum logic [1:0] {
        REG_WIN_LEN   = CFG_WINDOW_LENGTH,
        REG_MIN_LEVEL = CFG_MIN_LEVEL,
        REG_SPARE_A   = 2'd2,
        REG_SPARE_B   = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        ROW_BEAT = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        logic signed [DATA_W-1:0] smoothed;
        logic                     passed_raw;
    } t_smooth_beat;

    // One line of the directed table. For a beat row, data is the sample and reg_idx is unused.
    typedef struct packed {
        t_row_kind                kind;
        t_cfg_reg                 reg_idx;
        logic [DATA_W-1:0]        data;
        logic                     typed;
        logic signed [DATA_W-1:0] exp_smoothed;
        logic                     exp_raw;
    } t_stim_row;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic signed [DATA_W-1:0] i_sample     = '0;
    logic                     i_out_stall  = 1'b0;
    logic                     i_cfg_we     = 1'b0;
    logic [1:0]               i_cfg_index  = '0;
    logic [DATA_W-1:0]        i_cfg_data   = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_smoothed;
    logic                     o_passed_raw;

    sliding_window_kalman_smoother_core #(
        .WINDOW_MAX (WINDOW_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_smoothed   (o_smoothed),
        .o_passed_raw (o_passed_raw),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the window, the priming flag and both
    // registers, plus the Q0.16 gain of every window slot.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] win_mirror [WINDOW_MAX];
    logic [GAIN_W-1:0]        gain_tab   [WINDOW_MAX];
    logic                     primed_m  = 1'b0;
    logic [5:0]               len_reg   = WINDOW_LENGTH_RST;
    logic signed [DATA_W-1:0] min_lvl   = '0;
    // Slots 0 .. filled_slots-1 hold written samples. After priming, a window length is only
    // chosen when every slot it reads, apart from the newest, has been written.
    int                       filled_slots = 0;

    t_smooth_beat smooth_due [$];
    int           err_cnt      = 0;
    int           beats_sent   = 0;
    int           results_seen = 0;

    // floor(num * 2^32 / den) in two 16-bit long-division steps; num < den < 2^42.
    function automatic logic [63:0] q32_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = num;
        quo = '0;
        repeat (2) begin
            rem = rem << 16;
            quo = (quo << 16) | (rem / den);
            rem = rem % den;
        end
        return quo;
    endfunction

    // The register holds six bits; anything outside 2 .. WINDOW_MAX is clamped by the block.
    function automatic int eff_len(input logic [5:0] v);
        if (v < 6'd2) return 2;
        if (int'(v) > WINDOW_MAX) return WINDOW_MAX;
        return int'(v);
    endfunction

    // Works out the result of one accepted sample and advances the mirrored window.
    function automatic t_smooth_beat kalman_predict(input logic [DATA_W-1:0] raw);
        t_smooth_beat res;
        int           len;
        int           i;
        longint       est;
        longint       diff;
        len = eff_len(len_reg);
        res.smoothed   = raw;
        res.passed_raw = 1'b1;
        if (!primed_m) begin
            // The first sample that reaches the level fills all but the newest slot.
            if (signed'(raw) >= min_lvl) begin
                for (i = 0; i < len - 1; i++) win_mirror[i] = raw;
                primed_m     = 1'b1;
                filled_slots = len - 1;
            end
            return res;
        end
        win_mirror[len-1] = raw;
        if (filled_slots < len) filled_slots = len;
        est = 0;
        for (i = 0; i < len; i++) begin
            diff = longint'(win_mirror[i]) - est;
            est  = est + ((diff * longint'(gain_tab[i]) + 64'sd32768) >>> 16);
        end
        for (i = 0; i < len - 1; i++) win_mirror[i] = win_mirror[i+1];
        if (est > longint'(signed'(Q_MAX))) est = longint'(signed'(Q_MAX));
        if (est < longint'(signed'(Q_MIN))) est = longint'(signed'(Q_MIN));
        res.smoothed   = est[DATA_W-1:0];
        res.passed_raw = 1'b0;
        return res;
    endfunction

    // Length of one idle stretch: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Offers one sample and returns at the edge where the block takes it. The expectation is
    // the typed one where the table gives it; the predictor still runs to keep its state.
    task automatic push_sample(input logic [DATA_W-1:0] s, input logic typed,
                               input t_smooth_beat typed_beat);
        t_smooth_beat pred;
        int           gap;
        // Every fifth stretch of 64 beats the sender offers back to back.
        if ((beats_sent / 64) % 5 == 4 || $urandom_range(0, 99) < 55) gap = 0;
        else gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_sample   <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = kalman_predict(s);
        smooth_due.push_back(typed ? typed_beat : pred);
        beats_sent++;
    endtask

    // Waits until every expected beat has arrived and the block takes input again.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (smooth_due.size() != 0 || o_in_stall) @(posedge i_clk);
    endtask

    // Writes one register once the block has gone idle, and mirrors the write.
    task automatic write_reg(input t_cfg_reg idx, input logic [DATA_W-1:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_WIN_LEN: begin
                len_reg = data[5:0];
            end
            REG_MIN_LEVEL: begin
                min_lvl = data;
            end
            default: begin
                // Indexes past the register list are dropped by the block.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: checks every accepted beat against the oldest
    // expectation and drives i_out_stall in bursts of varying length.
    // ------------------------------------------------------------------
    int stall_left    = 0;
    bit pressure_done = 1'b0;

    always @(posedge i_clk) begin
        t_smooth_beat want;
        if (o_out_valid && !i_out_stall) begin
            if (smooth_due.size() == 0) begin
                $error("unexpected result beat: smoothed %0d passed_raw %0b",
                       o_smoothed, o_passed_raw);
                err_cnt++;
            end else begin
                want = smooth_due.pop_front();
                if (o_smoothed !== want.smoothed) begin
                    $error("smoothed: expected %0d, got %0d", want.smoothed, o_smoothed);
                    err_cnt++;
                end
                if (o_passed_raw !== want.passed_raw) begin
                    $error("passed_raw: expected %0b, got %0b", want.passed_raw, o_passed_raw);
                    err_cnt++;
                end
            end
            results_seen++;
        end
        // One long hold-off while the sender keeps offering, so that the output register
        // and the controller both fill and the block has to stall its input.
        if (!pressure_done && results_seen == PRESSURE_AT) begin
            stall_left    = PRESSURE_HOLD;
            pressure_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ((results_seen / 64) % 5 == 2) begin
            // A stretch in which every result is taken at once.
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 99) < 70) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_left  = idle_len() - 1;
            i_out_stall <= 1'b1;
        end
    end

    // Hard stop in case the block hangs or a result never comes.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, the directed table, then random phases, each of
    // which starts with fresh register settings on an idle block.
    // ------------------------------------------------------------------
    t_stim_row dir_rows [$];

    initial begin
        logic [63:0]       kq;
        t_stim_row         row;
        t_smooth_beat      typed_beat;
        logic [5:0]        len6;
        logic [DATA_W-1:0] lvl_word;
        logic [DATA_W-1:0] s;
        int                level;
        int                ph;
        int                b;
        int                r;
        int                g;

        // Q0.32 gain chain with a = 1/500, truncated each step, rounded to Q0.16.
        kq = q32_ratio(64'd100001, 64'd100501);
        for (g = 0; g < WINDOW_MAX; g++) begin
            gain_tab[g]   = GAIN_W'((kq + 64'd32768) >> 16);
            win_mirror[g] = '0;
            kq = q32_ratio(64'd500 * kq + (64'd1 << 32), 64'd500 * kq + 64'd501 * (64'd1 << 32));
        end

        // Before priming only the typed pass-through rows can be read off directly; once the
        // window runs, the predictor supplies the expectation. Samples below the level after
        // priming are filtered, and lengths 0, 1 and 63 exercise the clamp.
        dir_rows = '{
            '{ROW_BEAT, REG_WIN_LEN,   Q_MIN,         1'b1, Q_MIN,         1'b1},
            '{ROW_CFG,  REG_MIN_LEVEL, Q_MAX,         1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   32'hFFFF_FFFF, 1'b1, -32'sd1,       1'b1},
            '{ROW_BEAT, REG_WIN_LEN,   32'h0000_0000, 1'b1, 32'sd0,        1'b1},
            '{ROW_BEAT, REG_WIN_LEN,   32'h7FFF_FFFE, 1'b1, 32'h7FFF_FFFE, 1'b1},
            '{ROW_CFG,  REG_WIN_LEN,   32'hFFFF_FFFF, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MAX,         1'b1, Q_MAX,         1'b1},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MAX,         1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MIN,         1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MIN,         1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   32'h0000_0000, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   32'hFFFF_FFFF, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   32'h0000_0001, 1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_SPARE_A,   32'hDEAD_BEEF, 1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_SPARE_B,   32'h5A5A_5A5A, 1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_WIN_LEN,   32'h0000_0000, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MIN,         1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MAX,         1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_WIN_LEN,   32'h0000_0001, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   32'hFFFF_0000, 1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_MIN_LEVEL, Q_MIN,         1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_WIN_LEN,   32'h0000_0002, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   32'h0001_0000, 1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_WIN_LEN,   32'h0000_0020, 1'b0, 32'sd0,        1'b0},
            '{ROW_BEAT, REG_WIN_LEN,   Q_MIN,         1'b0, 32'sd0,        1'b0},
            '{ROW_CFG,  REG_MIN_LEVEL, 32'h0000_0000, 1'b0, 32'sd0,        1'b0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            typed_beat.smoothed   = row.exp_smoothed;
            typed_beat.passed_raw = row.exp_raw;
            if (row.kind == ROW_CFG) write_reg(row.reg_idx, row.data);
            else push_sample(row.data, row.typed, typed_beat);
        end

        // Random phases. The samples are mostly a noisy level with occasional steps, the
        // rest full-range words and extremes, so that every bit of the sample toggles.
        typed_beat = '0;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            do begin
                r = $urandom_range(0, 99);
                if (r < 10) len6 = 6'($urandom_range(0, 1));
                else if (r < 20) len6 = 6'($urandom_range(33, 63));
                else if (r < 30) len6 = 6'd2;
                else if (r < 40) len6 = 6'(WINDOW_MAX);
                else len6 = 6'($urandom_range(3, 12));
            end while (primed_m && eff_len(len6) - 1 > filled_slots);
            write_reg(REG_WIN_LEN, ($urandom & ~32'h3F) | {26'd0, len6});

            r = $urandom_range(0, 99);
            if (r < 25) lvl_word = Q_MIN;
            else if (r < 50) lvl_word = Q_MAX;
            else lvl_word = $urandom;
            write_reg(REG_MIN_LEVEL, lvl_word);
            if ($urandom_range(0, 2) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            end

            level = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
            for (b = 0; b < PHASE_BEATS; b++) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    s = $urandom;
                end else if (r < 25) begin
                    case ($urandom_range(0, 4))
                        0: s = Q_MIN;
                        1: s = Q_MAX;
                        2: s = 32'h0000_0000;
                        3: s = 32'hFFFF_FFFF;
                        default: s = 32'h0000_0001;
                    endcase
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        level = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
                    end
                    s = level + int'($urandom_range(0, 1 << 18)) - (1 << 17);
                end
                push_sample(s, 1'b0, typed_beat);
            end
        end

        // Let the last results drain, then allow the longest recursion to go by in case a
        // stray beat follows.
        wait_idle();
        repeat (4 * WINDOW_MAX) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/swks_pkg.sv
rtl/core/swks_dp.sv
rtl/core/swks_ctrl.sv
rtl/core/sliding_window_kalman_smoother_core.sv
bench/tb_top.sv
